[design/fmt_pkg.sv]
// fmt_pkg: shared types and constants of the foreign master table
package fmt_pkg;

    // number of entry slots in the table
    localparam int TABLE_DEPTH = 16;

    // input word layout
    localparam int TECH_W  = 8;
    localparam int PORT_W  = 16;
    localparam int UUID_W  = 48;
    localparam int SYNC_W  = 16;
    localparam int CNT_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int IN_W    = TECH_W + PORT_W + UUID_W;
    localparam int OUT_W   = 32;

    // max_records value after reset
    localparam logic [CNT_W-1:0] MAX_RECORDS_RST = 5'd5;

    // opcodes carried in tuser
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // saturating sync counter limit
    localparam logic [SYNC_W-1:0] SYNC_MAX = 16'hFFFF;

    // one table entry
    typedef struct packed {
        logic [TECH_W-1:0] tech;
        logic [PORT_W-1:0] port;
        logic [UUID_W-1:0] uuid;
        logic [SYNC_W-1:0] syncs;
    } t_entry;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_clear;
        logic hit;
        logic scan_done;
        logic out_busy;
    } t_sts;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

endpackage

[design/fmt_ctrl.sv]
// fmt_ctrl: sequencing of accept, table scan and commit for the foreign master table
module fmt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  fmt_pkg::t_sts i_sts,
    output fmt_pkg::t_cmd o_cmd
);

    fmt_pkg::t_state r_state;
    fmt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        unique case (r_state)
            fmt_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = fmt_pkg::S_SCAN;
                end
            end
            fmt_pkg::S_SCAN: begin
                if (i_sts.is_clear || i_sts.hit || i_sts.scan_done) begin
                    n_state = fmt_pkg::S_COMMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            fmt_pkg::S_COMMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = fmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/fmt_datapath.sv]
// fmt_datapath: entry memory, scan pointer, counters and result register
module fmt_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fmt_pkg::CNT_W-1:0]       i_cfg_wdata,
    input  logic [fmt_pkg::IN_W-1:0]        i_s_axis_tdata,
    input  logic                            i_s_axis_tuser,
    input  fmt_pkg::t_cmd                   i_cmd,
    output fmt_pkg::t_sts                   o_sts,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [fmt_pkg::OUT_W-1:0]       o_m_axis_tdata
);

    localparam int IW = (fmt_pkg::TABLE_DEPTH > 1) ? $clog2(fmt_pkg::TABLE_DEPTH) : 1;
    localparam int XW = fmt_pkg::CNT_W + 1;

    fmt_pkg::t_entry r_mem [fmt_pkg::TABLE_DEPTH];

    logic                              r_op;
    logic [fmt_pkg::TECH_W-1:0]        r_tech;
    logic [fmt_pkg::PORT_W-1:0]        r_port;
    logic [fmt_pkg::UUID_W-1:0]        r_uuid;
    logic [fmt_pkg::CNT_W-1:0]         r_max;
    logic [fmt_pkg::CNT_W-1:0]         r_used;
    logic [fmt_pkg::CNT_W-1:0]         r_next;
    logic [XW-1:0]                     r_idx;
    logic [XW-1:0]                     r_cmp_idx;
    logic                              r_cmp_vld;
    fmt_pkg::t_entry                   r_rd;
    logic                              r_out_valid;
    logic [fmt_pkg::OUT_W-1:0]         r_out_data;

    logic [fmt_pkg::CNT_W-1:0]         lim;
    logic [fmt_pkg::CNT_W-1:0]         ins_slot;
    logic [fmt_pkg::CNT_W-1:0]         ins_inc;
    logic                              match;
    logic                              hit;
    logic [fmt_pkg::CNT_W-1:0]         res_slot;
    logic                              res_new;
    logic [fmt_pkg::SYNC_W-1:0]        res_syncs;
    logic [fmt_pkg::CNT_W-1:0]         res_used;
    logic [fmt_pkg::CNT_W-1:0]         res_next;
    fmt_pkg::t_entry                   wr_entry;

    // effective table limit from max_records
    always_comb begin
        if (r_max == '0) begin
            lim = fmt_pkg::CNT_W'(1);
        end else if (int'(r_max) > fmt_pkg::TABLE_DEPTH) begin
            lim = fmt_pkg::CNT_W'(fmt_pkg::TABLE_DEPTH);
        end else begin
            lim = r_max;
        end
    end

    // key compare against the entry held in the read register r_rd
    assign match = (r_rd.tech == r_tech) && (r_rd.port == r_port) && (r_rd.uuid == r_uuid);
    assign hit   = r_cmp_vld && match;

    assign o_sts.is_clear  = (r_op == fmt_pkg::OP_CLEAR);
    assign o_sts.hit       = hit;
    assign o_sts.scan_done = !r_cmp_vld && (r_idx >= XW'(r_used));
    assign o_sts.out_busy  = r_out_valid && !i_m_axis_tready;

    // insert slot for a miss, wrapping at the limit
    assign ins_slot = (r_next < lim) ? r_next : '0;
    assign ins_inc  = fmt_pkg::CNT_W'(ins_slot + 1'b1);

    // result of the commit step
    always_comb begin
        res_used  = r_used;
        res_next  = r_next;
        res_slot  = '0;
        res_new   = 1'b0;
        res_syncs = '0;
        wr_entry  = r_rd;
        if (r_op == fmt_pkg::OP_CLEAR) begin
            res_used = '0;
            res_next = '0;
        end else if (hit) begin
            res_slot  = fmt_pkg::CNT_W'(r_cmp_idx);
            res_syncs = (r_rd.syncs == fmt_pkg::SYNC_MAX) ? r_rd.syncs
                                                          : r_rd.syncs + 1'b1;
            wr_entry.syncs = res_syncs;
        end else begin
            res_slot  = ins_slot;
            res_new   = 1'b1;
            res_syncs = fmt_pkg::SYNC_W'(1);
            res_used  = (r_used < lim) ? fmt_pkg::CNT_W'(r_used + 1'b1) : r_used;
            res_next  = (ins_inc >= lim) ? '0 : ins_inc;
            wr_entry.tech  = r_tech;
            wr_entry.port  = r_port;
            wr_entry.uuid  = r_uuid;
            wr_entry.syncs = res_syncs;
        end
    end

    // entry memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && (int'(r_idx) < fmt_pkg::TABLE_DEPTH)) begin
            r_rd <= r_mem[IW'(r_idx)];
        end
        if (i_cmd.commit && (r_op == fmt_pkg::OP_RECORD)) begin
            r_mem[IW'(res_slot)] <= wr_entry;
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_s_axis_tuser;
            r_tech <= i_s_axis_tdata[fmt_pkg::TECH_W-1:0];
            r_port <= i_s_axis_tdata[fmt_pkg::TECH_W +: fmt_pkg::PORT_W];
            r_uuid <= i_s_axis_tdata[fmt_pkg::TECH_W + fmt_pkg::PORT_W +: fmt_pkg::UUID_W];
        end
    end

    // scan pointer and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_idx <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx     <= XW'(r_idx + 1'b1);
            r_cmp_idx <= r_idx;
            r_cmp_vld <= (r_idx < XW'(r_used));
        end
    end

    // table counters and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= fmt_pkg::MAX_RECORDS_RST;
            r_used <= '0;
            r_next <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_used <= res_used;
                r_next <= res_next;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {6'd0, res_used, res_syncs, res_new,
                           fmt_pkg::SLOT_W'(res_slot)};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a hit always lies inside the valid part of the table
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (r_cmp_idx < XW'(r_used)))
        else $error("hit outside valid entries");

    // a commit never overwrites a word that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && !i_m_axis_tready))
        else $error("result overwritten");

    // a new entry leaves at least one valid entry
    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_op == fmt_pkg::OP_RECORD) && !hit) |=> (r_used != '0))
        else $error("valid count empty after insert");

    // valid count never exceeds the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (int'(r_used) <= fmt_pkg::TABLE_DEPTH))
        else $error("valid count above depth");
`endif

endmodule

[design/foreign_master_table.sv]
// foreign_master_table: top level of the foreign sync-source table
//
// Table of up to 16 sync sources keyed by technology, port id and
// 48-bit uuid. A record word (tuser opcode 0) scans the valid entries one per
// cycle through the single read port of the entry memory, then bumps the
// matching entry's saturating sync count or writes the key into the
// round-robin slot; a clear word (tuser opcode 1) empties the table. A record
// word passes the scan and commit states, ending the scan early on a hit;
// a clear word does no scan. The result sits in an output register, so the
// next word is taken while it waits. The user writes max_records through
// i_cfg_we / i_cfg_wdata only while idle; the block does not enforce this.
module foreign_master_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fmt_pkg::CNT_W-1:0]   i_cfg_wdata,     // max_records
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [fmt_pkg::IN_W-1:0]    i_s_axis_tdata,  // source_tech, source_port, source_uuid
    input  logic                        i_s_axis_tuser,  // opcode
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [fmt_pkg::OUT_W-1:0]   o_m_axis_tdata   // slot, was_new, sync_total, valid_count
);

    fmt_pkg::t_cmd cmd;
    fmt_pkg::t_sts sts;

    // sequencer
    fmt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // table storage and result path
    fmt_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
